// ===== rtl/core/jamv_pkg.sv =====
// Shared types and constants of the joystick axis-mode velocity block.
package jamv_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned MulAW    = 32;
  localparam int unsigned MulBW    = 17;
  localparam int unsigned ProdW    = MulAW + MulBW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEADZONE    = 3'd0,
    CFG_ALPHA       = 3'd1,
    CFG_MAX_VEL_PAN = 3'd2,
    CFG_MAX_VEL_TLT = 3'd3,
    CFG_MAX_VEL_ROL = 3'd4,
    CFG_VEL_SCALE   = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT_MUL,
    ST_FILT_UPD,
    ST_VEL_MUL,
    ST_SCALE_MUL,
    ST_ROUND
  } state_e;

  localparam logic [2:0] MODE_PAN  = 3'd0;
  localparam logic [2:0] MODE_TILT = 3'd1;
  localparam logic [2:0] MODE_ROLL = 3'd2;
  localparam logic [2:0] MODE_AUTO = 3'd3;
  localparam logic [2:0] MODE_OFF  = 3'd4;

  localparam logic [14:0] DeadzoneRst = 15'd1638;
  localparam logic [15:0] AlphaRst    = 16'd6554;
  localparam logic [14:0] MaxVelRst   = 15'd256;
  localparam logic [15:0] ScaleRst    = 16'd256;

endpackage

// ===== rtl/core/jamv_if.sv =====
// Handshake channel interfaces for input items, result items and register writes.
interface jamv_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] joystick_y;
  logic               button_level;
  logic signed [15:0] auto_pan;
  logic signed [15:0] auto_tilt;
  logic signed [15:0] auto_roll;

  modport source (output valid, joystick_y, button_level, auto_pan, auto_tilt, auto_roll,
                  input ready);
  modport sink (input valid, joystick_y, button_level, auto_pan, auto_tilt, auto_roll,
                output ready);
endinterface

interface jamv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pan_velocity;
  logic signed [15:0] tilt_velocity;
  logic signed [15:0] roll_velocity;
  logic        [2:0]  current_mode;
  logic               command_valid;

  modport source (output valid, pan_velocity, tilt_velocity, roll_velocity, current_mode,
                  command_valid, input ready);
  modport sink (input valid, pan_velocity, tilt_velocity, roll_velocity, current_mode,
                command_valid, output ready);
endinterface

interface jamv_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [jamv_pkg::CfgIdxW-1:0]  index;
  logic [jamv_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/joystick_axis_mode_velocity_core.sv =====
// Top level of the joystick axis-mode velocity block.
//
// The input channel takes one joystick packet per item: Y deflection, button
// level and three automatic-mode velocities. The result channel returns one
// item per packet with three axis velocities, the current mode and a command
// flag. The configuration channel writes one of six registers per item and is
// always ready; the user must write it only while the block is idle, and the
// block itself does not enforce this. A packet runs through a sequencer that
// uses one multiplier three times: filter weight, axis velocity and overall
// scale. The result is loaded into the output register from the final
// rounding step, and no new packet is taken until the last one has left it.
// The output register decouples the two sides: when the receiver stalls, the
// block still accepts the next packet and holds it in the final rounding
// step until the output register frees.
// Reset clears the mode to pan, the previous button to pressed, the filter
// state to zero and loads the register defaults.
module joystick_axis_mode_velocity_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  jamv_in_if.sink     in_i,
  jamv_out_if.source  out_o,
  jamv_cfg_if.sink    cfg_i
);

  jamv_pkg::state_e state_q, state_d;

  logic [14:0] deadzone_q;
  logic [15:0] alpha_q;
  logic [14:0] mv_pan_q, mv_tilt_q, mv_roll_q;
  logic [15:0] scale_q;

  logic [2:0]         mode_q;
  logic               prev_btn_q;
  logic signed [15:0] smooth_q;
  logic signed [16:0] diff_q;
  logic signed [15:0] auto_pan_q, auto_tilt_q, auto_roll_q;

  logic               out_valid_q;
  logic signed [15:0] out_pan_q, out_tilt_q, out_roll_q;
  logic [2:0]         out_mode_q;
  logic               out_cmd_q;
  logic signed [15:0] out_pan_d, out_tilt_d, out_roll_d;
  logic               out_cmd_d;

  logic                                in_acc;
  logic                                mul_en;
  logic signed [jamv_pkg::MulAW-1:0]   mul_a;
  logic signed [jamv_pkg::MulBW-1:0]   mul_b;
  logic signed [jamv_pkg::ProdW-1:0]   prod;
  logic                                out_load;
  logic [14:0]                         mv_sel;

  logic [2:0]         mode_next;
  logic [15:0]        y_mag;
  logic signed [15:0] sample;

  logic [33:0]        f_mag;
  logic [33:0]        f_sum;
  logic signed [18:0] f_inc;
  logic signed [19:0] f_acc;
  logic signed [15:0] smooth_new;

  logic [46:0]        q_mag;
  logic [46:0]        q_sum;
  logic [23:0]        q_rnd;
  logic signed [15:0] vel;

  jamv_pkg::cfg_idx_e cfg_idx;

  assign cfg_i.ready = 1'b1;
  assign cfg_idx     = jamv_pkg::cfg_idx_e'(cfg_i.index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= jamv_pkg::DeadzoneRst;
      alpha_q    <= jamv_pkg::AlphaRst;
      mv_pan_q   <= jamv_pkg::MaxVelRst;
      mv_tilt_q  <= jamv_pkg::MaxVelRst;
      mv_roll_q  <= jamv_pkg::MaxVelRst;
      scale_q    <= jamv_pkg::ScaleRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx)
        jamv_pkg::CFG_DEADZONE:    deadzone_q <= cfg_i.data[14:0];
        jamv_pkg::CFG_ALPHA:       alpha_q    <= cfg_i.data;
        jamv_pkg::CFG_MAX_VEL_PAN: mv_pan_q   <= cfg_i.data[14:0];
        jamv_pkg::CFG_MAX_VEL_TLT: mv_tilt_q  <= cfg_i.data[14:0];
        jamv_pkg::CFG_MAX_VEL_ROL: mv_roll_q  <= cfg_i.data[14:0];
        jamv_pkg::CFG_VEL_SCALE:   scale_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign in_acc = in_i.valid && in_i.ready;

  // Mode advance on a button rising edge, then the deadzone on the sample.
  always_comb begin
    mode_next = mode_q;
    if (in_i.button_level && !prev_btn_q) begin
      mode_next = (mode_q >= jamv_pkg::MODE_OFF) ? jamv_pkg::MODE_PAN : mode_q + 3'd1;
    end
    y_mag  = in_i.joystick_y[15] ? 16'(-in_i.joystick_y) : 16'(in_i.joystick_y);
    sample = (y_mag < {1'b0, deadzone_q}) ? 16'sd0 : in_i.joystick_y;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jamv_pkg::ST_IDLE:      if (in_acc) state_d = jamv_pkg::ST_FILT_MUL;
      jamv_pkg::ST_FILT_MUL:  state_d = jamv_pkg::ST_FILT_UPD;
      jamv_pkg::ST_FILT_UPD:  state_d = jamv_pkg::ST_VEL_MUL;
      jamv_pkg::ST_VEL_MUL:   state_d = jamv_pkg::ST_SCALE_MUL;
      jamv_pkg::ST_SCALE_MUL: state_d = jamv_pkg::ST_ROUND;
      jamv_pkg::ST_ROUND:     if (out_load) state_d = jamv_pkg::ST_IDLE;
      default:                state_d = jamv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (mode_q)
      jamv_pkg::MODE_PAN:  mv_sel = mv_pan_q;
      jamv_pkg::MODE_TILT: mv_sel = mv_tilt_q;
      default:             mv_sel = mv_roll_q;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    out_load   = 1'b0;
    unique case (state_q)
      jamv_pkg::ST_IDLE: in_i.ready = 1'b1;
      jamv_pkg::ST_FILT_MUL: begin
        mul_en = 1'b1;
        mul_a  = jamv_pkg::MulAW'(diff_q);
        mul_b  = $signed({1'b0, alpha_q});
      end
      jamv_pkg::ST_VEL_MUL: begin
        mul_en = 1'b1;
        mul_a  = jamv_pkg::MulAW'(smooth_q);
        mul_b  = $signed({2'b00, mv_sel});
      end
      jamv_pkg::ST_SCALE_MUL: begin
        mul_en = 1'b1;
        mul_a  = prod[jamv_pkg::MulAW-1:0];
        mul_b  = $signed({1'b0, scale_q});
      end
      jamv_pkg::ST_ROUND: out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  jamv_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Filter increment: product over 2^16, rounded half away from zero.
  always_comb begin
    f_mag = prod[33] ? 34'(-prod[33:0]) : prod[33:0];
    f_sum = f_mag + 34'd32768;
    f_inc = prod[33] ? -$signed({1'b0, f_sum[33:16]}) : $signed({1'b0, f_sum[33:16]});
    f_acc = 20'(smooth_q) + 20'(f_inc);
    if (f_acc > 20'sd32767) begin
      smooth_new = 16'sh7fff;
    end else if (f_acc < -20'sd32768) begin
      smooth_new = -16'sd32768;
    end else begin
      smooth_new = f_acc[15:0];
    end
  end

  // Velocity: product over 2^23, rounded half away from zero, saturated.
  always_comb begin
    q_mag = prod[46] ? 47'(-prod[46:0]) : prod[46:0];
    q_sum = q_mag + 47'd4194304;
    q_rnd = q_sum[46:23];
    if (!prod[46]) begin
      vel = (q_rnd > 24'd32767) ? 16'sh7fff : $signed(q_rnd[15:0]);
    end else begin
      vel = (q_rnd > 24'd32768) ? -16'sd32768 : $signed(16'(-q_rnd[15:0]));
    end
  end

  always_comb begin
    out_pan_d  = '0;
    out_tilt_d = '0;
    out_roll_d = '0;
    out_cmd_d  = 1'b1;
    case (mode_q)
      jamv_pkg::MODE_PAN:  out_pan_d  = vel;
      jamv_pkg::MODE_TILT: out_tilt_d = vel;
      jamv_pkg::MODE_ROLL: out_roll_d = vel;
      jamv_pkg::MODE_AUTO: begin
        out_pan_d  = auto_pan_q;
        out_tilt_d = auto_tilt_q;
        out_roll_d = auto_roll_q;
      end
      default: out_cmd_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jamv_pkg::ST_IDLE;
      mode_q      <= jamv_pkg::MODE_PAN;
      prev_btn_q  <= 1'b1;
      smooth_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        mode_q     <= mode_next;
        prev_btn_q <= in_i.button_level;
      end
      if (state_q == jamv_pkg::ST_FILT_UPD) begin
        smooth_q <= smooth_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      diff_q      <= 17'(sample) - 17'(smooth_q);
      auto_pan_q  <= in_i.auto_pan;
      auto_tilt_q <= in_i.auto_tilt;
      auto_roll_q <= in_i.auto_roll;
    end
    if (out_load) begin
      out_mode_q <= mode_q;
      out_pan_q  <= out_pan_d;
      out_tilt_q <= out_tilt_d;
      out_roll_q <= out_roll_d;
      out_cmd_q  <= out_cmd_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pan_velocity  = out_pan_q;
  assign out_o.tilt_velocity = out_tilt_q;
  assign out_o.roll_velocity = out_roll_q;
  assign out_o.current_mode  = out_mode_q;
  assign out_o.command_valid = out_cmd_q;

endmodule

// ===== rtl/core/jamv_mul.sv =====
// Shared signed multiplier with a registered product.
module jamv_mul (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [jamv_pkg::MulAW-1:0]  a_i,
  input  logic signed [jamv_pkg::MulBW-1:0]  b_i,
  output logic signed [jamv_pkg::ProdW-1:0]  prod_o
);

  logic signed [jamv_pkg::ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/core/jamv_checker.sv =====
// Port-level checks of the joystick axis-mode velocity block and their binding.
module jamv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] pan_i,
  input logic [15:0] tilt_i,
  input logic [15:0] roll_i,
  input logic [2:0]  mode_i,
  input logic        cmd_i
);

  // The sequencer takes one packet at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready again right after an accepted item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(pan_i) && $stable(tilt_i)
      && $stable(roll_i) && $stable(mode_i) && $stable(cmd_i)))
    else $error("stalled result item changed or dropped");

  a_off_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !cmd_i) |-> (pan_i == 16'd0 && tilt_i == 16'd0 && roll_i == 16'd0))
    else $error("velocity issued without a command");

  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (mode_i <= jamv_pkg::MODE_OFF &&
      (cmd_i == (mode_i != jamv_pkg::MODE_OFF))))
    else $error("mode out of range or command flag inconsistent");

  a_single_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && mode_i == jamv_pkg::MODE_PAN) |-> (tilt_i == 16'd0 && roll_i == 16'd0))
    else $error("pan mode drives another axis");

endmodule

bind joystick_axis_mode_velocity_core jamv_checker u_jamv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pan_i       (out_o.pan_velocity),
  .tilt_i      (out_o.tilt_velocity),
  .roll_i      (out_o.roll_velocity),
  .mode_i      (out_o.current_mode),
  .cmd_i       (out_o.command_valid)
);
